[rtl/bdqd_pkg.sv]
package bdqd_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE     = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // per-cycle action broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,    // keep contents
        OP_SHR,     // take left neighbor (push front)
        OP_SHL,     // take right neighbor (pop front)
        OP_LOAD,    // first free slot takes value (push back)
        OP_SCAN     // delete scan: token cell pulls from the right on a match or after one
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [VALUE_W-1:0]   value;
        logic                 found;    // a match was already seen in this scan
        logic                 start;    // inject scan token at cell 0
        logic                 advance;  // token keeps moving
    } cell_cmd_t;

endpackage

[rtl/bdqd_cell.sv]
module bdqd_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bdqd_pkg::cell_cmd_t           cmd,
    input  logic [CNT_W-1:0]              count,
    input  logic [bdqd_pkg::VALUE_W-1:0]  left_data,
    input  logic [bdqd_pkg::VALUE_W-1:0]  right_data,
    input  logic                          tok_in,
    output logic [bdqd_pkg::VALUE_W-1:0]  data,
    output logic                          tok,
    output logic                          hit,
    output logic [bdqd_pkg::VALUE_W-1:0]  tail_data
);
    import bdqd_pkg::*;

    logic [VALUE_W-1:0] data_reg, data_next;
    logic               tok_reg, tok_next;
    logic               is_free, is_tail, match;

    assign is_free = (count == CNT_W'(IDX));
    assign is_tail = (count == CNT_W'(IDX + 1));
    assign match   = (data_reg == cmd.value);

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            OP_SHR:  data_next = left_data;
            OP_SHL:  data_next = right_data;
            OP_LOAD: begin
                if (is_free) begin
                    data_next = cmd.value;
                end
            end
            OP_SCAN: begin
                if (tok_reg && (cmd.found || match)) begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
        tok_next = tok_in & cmd.advance;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign tok       = tok_reg;
    assign hit       = tok_reg & match;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

[rtl/bounded_deque_with_delete_core.sv]
// Bounded double-ended queue of signed 32-bit values with delete by value.
//
// Input channel (s_*): one request per handshake carries func and value.
//   func: push front, push back, pop front, pop back, delete first match.
// Result channel (m_*): exactly one result per request, in request order:
//   popped value (zero unless a pop succeeded), status, occupancy after.
//
// Storage is a row of DEPTH cells, position 0 at the front. Push front and pop
// front shift every cell at once, push back loads the first free cell and pop
// back only lowers the count; the result appears the cycle after acceptance.
// Delete walks a token down the row one cell per cycle (on an empty queue it
// answers not found with no walk); cells at and behind the first match pull
// from their right neighbor as the token passes, closing the gap in the walk.
//
// One request is in flight at a time. s_tready drops while a delete walks
// or while a result waits in the output register with m_tready low; the
// result stays stable until taken. Reset empties the queue and the output
// register; cell contents are left as they are and never read unwritten.
module bounded_deque_with_delete_core #(
    parameter int  DEPTH = 16,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((34 + CNT_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // [2:0] func, [34:3] value, rest zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [31:0] popped_value, [33:32] status,
                                        // [33+CNT_W:34] occupancy, rest zero
);
    import bdqd_pkg::*;

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                found_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  popped_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CNT_W-1:0]    occ_reg;

    logic [FUNC_W-1:0]   in_func;
    logic [VALUE_W-1:0]  in_value;
    logic                accept, full, empty, scan_last, any_hit, found_now;
    logic [VALUE_W-1:0]  tail_value;
    cell_cmd_t           cmd;

    logic [VALUE_W-1:0]  cell_data [DEPTH];
    logic [VALUE_W-1:0]  cell_tail [DEPTH];
    logic [DEPTH-1:0]    cell_tok;
    logic [DEPTH-1:0]    cell_hit;

    assign in_func  = s_tdata[2:0];
    assign in_value = s_tdata[34:3];

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign scan_last = (idx_reg == (count_reg - CNT_W'(1)));
    assign any_hit  = |cell_hit;
    assign found_now = found_reg | any_hit;

    // pop-back read: only the last occupied cell drives its tail output
    always_comb begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    // command broadcast to the cell row
    always_comb begin
        cmd.op      = OP_HOLD;
        cmd.value   = in_value;
        cmd.found   = 1'b0;
        cmd.start   = 1'b0;
        cmd.advance = 1'b0;
        if (state_reg == S_SCAN) begin
            cmd.op      = OP_SCAN;
            cmd.value   = value_reg;
            cmd.found   = found_reg;
            cmd.advance = !scan_last;
        end else if (accept) begin
            case (in_func)
                FUNC_PUSH_FRONT: if (!full)  cmd.op = OP_SHR;
                FUNC_PUSH_BACK:  if (!full)  cmd.op = OP_LOAD;
                FUNC_POP_FRONT:  if (!empty) cmd.op = OP_SHL;
                FUNC_DELETE: begin
                    if (!empty) begin
                        cmd.start   = 1'b1;
                        cmd.advance = 1'b1;
                    end
                end
                default: cmd.op = OP_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] left_d, right_d;
        logic               tok_left;
        if (g == 0) begin : g_head
            assign left_d   = cmd.value;
            assign tok_left = cmd.start;
        end else begin : g_mid
            assign left_d   = cell_data[g-1];
            assign tok_left = cell_tok[g-1];
        end
        if (g == DEPTH - 1) begin : g_end
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = cell_data[g+1];
        end

        bdqd_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .count      (count_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .tok_in     (tok_left),
            .data       (cell_data[g]),
            .tok        (cell_tok[g]),
            .hit        (cell_hit[g]),
            .tail_data  (cell_tail[g])
        );
    end

    // control: queue count, delete walk and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        popped_reg <= '0;
                        status_reg <= ST_OK;
                        occ_reg    <= count_reg;
                        m_tvalid_reg <= 1'b1;
                        case (in_func)
                            FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                                if (full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    occ_reg   <= count_reg + CNT_W'(1);
                                end
                            end
                            FUNC_POP_FRONT: begin
                                if (empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    popped_reg <= cell_data[0];
                                    count_reg  <= count_reg - CNT_W'(1);
                                    occ_reg    <= count_reg - CNT_W'(1);
                                end
                            end
                            FUNC_POP_BACK: begin
                                if (empty) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    popped_reg <= tail_value;
                                    count_reg  <= count_reg - CNT_W'(1);
                                    occ_reg    <= count_reg - CNT_W'(1);
                                end
                            end
                            FUNC_DELETE: begin
                                if (empty) begin
                                    status_reg <= ST_NOTFOUND;
                                end else begin
                                    // result comes at the end of the walk
                                    m_tvalid_reg <= 1'b0;
                                    state_reg    <= S_SCAN;
                                    idx_reg      <= '0;
                                    found_reg    <= 1'b0;
                                    value_reg    <= in_value;
                                end
                            end
                            default: status_reg <= ST_OK;
                        endcase
                    end
                end
                S_SCAN: begin
                    found_reg <= found_now;
                    idx_reg   <= idx_reg + CNT_W'(1);
                    if (scan_last) begin
                        state_reg    <= S_IDLE;
                        m_tvalid_reg <= 1'b1;
                        popped_reg   <= '0;
                        status_reg   <= found_now ? ST_OK : ST_NOTFOUND;
                        if (found_now) begin
                            count_reg <= count_reg - CNT_W'(1);
                            occ_reg   <= count_reg - CNT_W'(1);
                        end else begin
                            occ_reg   <= count_reg;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({occ_reg, status_reg, popped_reg});

endmodule
